// ===== sv/mhpq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and constants shared by the priority queue modules.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] score;
        logic [15:0]        client_id;
        logic signed [15:0] cur_x;
        logic signed [15:0] cur_y;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_score;
        logic [15:0]        out_id;
        logic signed [15:0] out_cur_x;
        logic signed [15:0] out_cur_y;
        logic signed [15:0] out_dest_x;
        logic signed [15:0] out_dest_y;
        logic [6:0]         occupancy;
    } out_item_t;

    // One stored record: identifier, score and the four coordinates.
    typedef struct packed {
        logic [15:0]        id;
        logic signed [31:0] score;
        logic [63:0]        pay;
    } rec_t;

endpackage
`default_nettype wire

// ===== sv/max_heap_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of client records held in one two-read memory.
// ----------------------------------------------------------------------------
// Insert writes the record into the next free slot and moves it up a level at a
// time; remove maximum refills the top slot with the last record, unless that
// record leaves, and moves it down, then checks upward; remove by identifier
// searches the entries in order, then refills the found slot the same way. One
// operation at a time: a new transfer is taken in the cycle after the result transfer.
// Reset clears the record count; the memory holds no reset state.
module max_heap_priority_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire mhpq_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output mhpq_pkg::out_item_t      out_data
);
    localparam int AW = mhpq_pkg::AW;
    localparam int CW = mhpq_pkg::CW;

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_TAKE_RD, S_TAKE_GET, S_DN_RD, S_DN_CMP,
        S_UP2_RD, S_UP2_CMP, S_SRCH_RD, S_SRCH_CMP, S_OUT
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic [CW:0]       idx_reg;     // current slot, one bit wider for child math
    mhpq_pkg::rec_t    cur_reg;     // record being moved
    mhpq_pkg::out_item_t res_reg;

    logic              we;
    logic [AW-1:0]     waddr, ra, rb;
    mhpq_pkg::rec_t    wdata, rda, rdb;

    mhpq_ram u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
    );

    logic [CW:0] lc, rc, par, cnt_ext;
    assign lc      = {idx_reg[CW-1:0], 1'b1};
    assign rc      = lc + 1'b1;
    assign par     = (idx_reg - 1'b1) >> 1;
    assign cnt_ext = {1'b0, count_reg};

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    // Read addresses and write port depend on the current state.
    always_comb
    begin
        ra    = idx_reg[AW-1:0];
        rb    = idx_reg[AW-1:0];
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = cur_reg;
        case (state_reg)
            S_UP_RD:    ra = par[AW-1:0];
            S_UP2_RD:   ra = par[AW-1:0];
            // A search compare also fetches the last record for a possible refill.
            S_TAKE_RD, S_SRCH_CMP:
            begin
                ra = idx_reg[AW-1:0];
                rb = count_reg[AW-1:0] - 1'b1;
            end
            S_DN_RD:
            begin
                ra = lc[AW-1:0];
                rb = rc[AW-1:0];
            end
            default: ;
        endcase
        // Up and down steps write the other record or the moved one to this slot.
        if (state_reg == S_UP_CMP || state_reg == S_UP2_CMP)
        begin
            if (idx_reg != '0 && rda.score < cur_reg.score)
            begin
                we = 1'b1; wdata = rda;
            end
            else
            begin
                we = 1'b1;
            end
        end
        else if (state_reg == S_DN_CMP)
        begin
            we = 1'b1;
            if (lc < cnt_ext && rda.score > cur_reg.score &&
                !(rc < cnt_ext && rdb.score > rda.score))
                wdata = rda;
            else if (rc < cnt_ext && rdb.score > cur_reg.score &&
                     !(lc < cnt_ext && rda.score >= rdb.score))
                wdata = rdb;
        end
        else if (state_reg == S_IDLE && in_valid &&
                 in_data.mode == mhpq_pkg::MODE_INSERT &&
                 count_reg < CW'(mhpq_pkg::CAPACITY))
        begin
            we    = 1'b1;
            waddr = count_reg[AW-1:0];
            wdata = '{in_data.client_id, in_data.score,
                      {in_data.dest_y, in_data.dest_x, in_data.cur_y, in_data.cur_x}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        res_reg  <= '0;
                        idx_reg  <= '0;
                        cur_reg  <= '{in_data.client_id, in_data.score,
                                      {in_data.dest_y, in_data.dest_x,
                                       in_data.cur_y, in_data.cur_x}};
                        case (in_data.mode)
                            mhpq_pkg::MODE_INSERT:
                                if (count_reg >= CW'(mhpq_pkg::CAPACITY))
                                begin
                                    res_reg.status    <= mhpq_pkg::ST_FULL;
                                    res_reg.occupancy <= 7'(count_reg);
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    idx_reg   <= {1'b0, count_reg};
                                    count_reg <= count_reg + 1'b1;
                                    state_reg <= S_UP_RD;
                                end
                            mhpq_pkg::MODE_POP, mhpq_pkg::MODE_REMOVE:
                                if (count_reg == '0)
                                begin
                                    res_reg.status <= mhpq_pkg::ST_EMPTY;
                                    state_reg <= S_OUT;
                                end
                                else
                                    state_reg <= (in_data.mode == mhpq_pkg::MODE_POP)
                                                 ? S_TAKE_RD : S_SRCH_RD;
                            default:
                            begin
                                res_reg.occupancy <= 7'(count_reg);
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_UP_RD, S_UP2_RD:
                    state_reg <= (state_reg == S_UP_RD) ? S_UP_CMP : S_UP2_CMP;
                S_UP_CMP, S_UP2_CMP:
                    if (idx_reg != '0 && rda.score < cur_reg.score)
                    begin
                        idx_reg   <= par;
                        state_reg <= (state_reg == S_UP_CMP) ? S_UP_RD : S_UP2_RD;
                    end
                    else
                    begin
                        res_reg.occupancy <= 7'(count_reg);
                        state_reg <= S_OUT;
                    end
                S_SRCH_RD:
                    state_reg <= S_SRCH_CMP;
                S_SRCH_CMP:
                    if (rda.id == cur_reg.id)
                        state_reg <= S_TAKE_GET;
                    else if (idx_reg + 1'b1 >= cnt_ext)
                    begin
                        res_reg.status    <= mhpq_pkg::ST_NOTFOUND;
                        res_reg.occupancy <= 7'(count_reg);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SRCH_RD;
                    end
                S_TAKE_RD:
                    state_reg <= S_TAKE_GET;
                S_TAKE_GET:
                begin
                    // Port A holds the removed record, port B the last record.
                    res_reg.out_score  <= rda.score;
                    res_reg.out_id     <= rda.id;
                    res_reg.out_cur_x  <= rda.pay[15:0];
                    res_reg.out_cur_y  <= rda.pay[31:16];
                    res_reg.out_dest_x <= rda.pay[47:32];
                    res_reg.out_dest_y <= rda.pay[63:48];
                    count_reg <= count_reg - 1'b1;
                    res_reg.occupancy <= 7'(count_reg - 1'b1);
                    cur_reg   <= rdb;
                    if (idx_reg >= cnt_ext - 1'b1)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_DN_RD;
                end
                S_DN_RD:
                    state_reg <= S_DN_CMP;
                S_DN_CMP:
                    if (lc < cnt_ext && rda.score > cur_reg.score &&
                        !(rc < cnt_ext && rdb.score > rda.score))
                    begin
                        idx_reg <= lc; state_reg <= S_DN_RD;
                    end
                    else if (rc < cnt_ext && rdb.score > cur_reg.score &&
                             !(lc < cnt_ext && rda.score >= rdb.score))
                    begin
                        idx_reg <= rc; state_reg <= S_DN_RD;
                    end
                    else
                        state_reg <= S_UP2_RD;
                S_OUT:
                    if (!out_stall)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/mhpq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ram
// Record memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mhpq_ram (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [mhpq_pkg::AW-1:0] waddr,
    input  wire mhpq_pkg::rec_t        wdata,
    input  wire logic [mhpq_pkg::AW-1:0] raddr_a,
    input  wire logic [mhpq_pkg::AW-1:0] raddr_b,
    output mhpq_pkg::rec_t             rdata_a,
    output mhpq_pkg::rec_t             rdata_b
);
    mhpq_pkg::rec_t mem [mhpq_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
`default_nettype wire
